/* rtl/bmhq_pkg.sv */
// Shared constants, codes and types of the binary max-heap queue.
`default_nettype none

package bmhq_pkg;

   localparam int CAPACITY    = 1024;
   localparam int VALUE_W     = 32;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = ADDR_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POLL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_POLL,
      OP_PEEK,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_ROOT,
      ENG_UP,
      ENG_DOWN,
      ENG_PLACE,
      ENG_FINISH
   } engine_state_type;

endpackage

`default_nettype wire

/* rtl/binary_max_heap_queue_top.sv */
// Throughput: one operation at a time in the engine; the heap walk, one level per cycle
// on a memory with two read ports and one write port, sets the rate.
// A two-entry command queue and a result register decouple both sides.
// Reset (synchronous) empties the heap and both queues; no clearing pass is needed.
`default_nettype none

module binary_max_heap_queue_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [bmhq_pkg::MODE_W-1:0]          req_mode,
   input  wire logic signed [bmhq_pkg::VALUE_W-1:0]  req_new_value,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic signed [bmhq_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic [bmhq_pkg::STATUS_W-1:0]             rsp_status,
   output logic [bmhq_pkg::CNT_W-1:0]                rsp_entries_after
);

   logic              cmd_valid;
   logic              cmd_pop;
   bmhq_pkg::cmd_type cmd;

   bmhq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_mode      (req_mode),
      .req_new_value (req_new_value),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   bmhq_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_entries_after (rsp_entries_after)
   );

endmodule

`default_nettype wire

/* rtl/bmhq_front.sv */
// Front end: decodes incoming transactions into commands and queues them for the engine.
`default_nettype none

module bmhq_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [bmhq_pkg::MODE_W-1:0]          req_mode,
   input  wire logic signed [bmhq_pkg::VALUE_W-1:0]  req_new_value,
   output logic                                      cmd_valid,
   output bmhq_pkg::cmd_type                         cmd,
   input  wire logic                                 cmd_pop
);

   bmhq_pkg::cmd_type                 queue_ff [bmhq_pkg::QUEUE_DEPTH];
   logic [bmhq_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bmhq_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bmhq_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   bmhq_pkg::cmd_type                 decoded;
   logic                              do_push;
   logic                              do_pop;

   always_comb begin
      decoded.value = req_new_value;
      case (req_mode)
         bmhq_pkg::MODE_INSERT: decoded.op = bmhq_pkg::OP_INSERT;
         bmhq_pkg::MODE_POLL:   decoded.op = bmhq_pkg::OP_POLL;
         bmhq_pkg::MODE_PEEK:   decoded.op = bmhq_pkg::OP_PEEK;
         default:               decoded.op = bmhq_pkg::OP_NOP;
      endcase
   end

   assign req_full  = (fill_ff == bmhq_pkg::QCNT_W'(bmhq_pkg::QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

/* rtl/bmhq_engine.sv */
// Back end: heap store, sift-up and sift-down sequencer, and the result register.
`default_nettype none

module bmhq_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 cmd_valid,
   input  wire bmhq_pkg::cmd_type                    cmd,
   output logic                                      cmd_pop,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic signed [bmhq_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic [bmhq_pkg::STATUS_W-1:0]             rsp_status,
   output logic [bmhq_pkg::CNT_W-1:0]                rsp_entries_after
);

   logic signed [bmhq_pkg::VALUE_W-1:0] heap_mem [bmhq_pkg::CAPACITY];

   bmhq_pkg::engine_state_type           state_ff, state_in;
   logic [bmhq_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [bmhq_pkg::ADDR_W-1:0]          hole_ff, hole_in;
   logic signed [bmhq_pkg::VALUE_W-1:0]  move_ff, move_in;
   bmhq_pkg::op_type                     op_ff, op_in;
   logic                                 rt_ok_ff, rt_ok_in;
   logic signed [bmhq_pkg::VALUE_W-1:0]  res_value_ff, res_value_in;
   bmhq_pkg::status_type                 res_status_ff, res_status_in;

   logic                                 rsp_valid_ff;
   logic signed [bmhq_pkg::VALUE_W-1:0]  rsp_value_ff;
   bmhq_pkg::status_type                 rsp_status_ff;
   logic [bmhq_pkg::CNT_W-1:0]           rsp_count_ff;
   logic                                 out_load;

   logic                                 wr_en;
   logic [bmhq_pkg::ADDR_W-1:0]          wr_addr;
   logic signed [bmhq_pkg::VALUE_W-1:0]  wr_data;
   logic [bmhq_pkg::ADDR_W-1:0]          rd_a_addr, rd_b_addr;
   logic signed [bmhq_pkg::VALUE_W-1:0]  rd_a_data_ff, rd_b_data_ff;

   logic [bmhq_pkg::ADDR_W-1:0]          up_parent;
   logic [bmhq_pkg::IDX_W-1:0]           left_cur;
   logic                                 pick_right;
   logic [bmhq_pkg::ADDR_W-1:0]          pick_idx;
   logic signed [bmhq_pkg::VALUE_W-1:0]  pick_val;
   logic [bmhq_pkg::IDX_W-1:0]           next_left;
   logic [bmhq_pkg::IDX_W-1:0]           next_right;
   logic [bmhq_pkg::CNT_W-1:0]           count_dec;
   logic [bmhq_pkg::IDX_W-1:0]           count_ext;
   logic [bmhq_pkg::IDX_W-1:0]           count_dec_ext;

   assign up_parent     = (hole_ff - 1'b1) >> 1;
   assign left_cur      = {hole_ff, 1'b1};
   assign pick_right    = rt_ok_ff && (rd_b_data_ff > rd_a_data_ff);
   assign pick_idx      = bmhq_pkg::ADDR_W'(left_cur + {{(bmhq_pkg::IDX_W-1){1'b0}}, pick_right});
   assign pick_val      = pick_right ? rd_b_data_ff : rd_a_data_ff;
   assign next_left     = {pick_idx, 1'b1};
   assign next_right    = next_left + 1'b1;
   assign count_dec     = count_ff - 1'b1;
   assign count_ext     = bmhq_pkg::IDX_W'(count_ff);
   assign count_dec_ext = bmhq_pkg::IDX_W'(count_dec);
   assign out_load      = (state_ff == bmhq_pkg::ENG_FINISH) && (!rsp_valid_ff || rsp_pop);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      hole_in       = hole_ff;
      move_in       = move_ff;
      op_in         = op_ff;
      rt_ok_in      = rt_ok_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = hole_ff;
      wr_data       = move_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;

      case (state_ff)
         bmhq_pkg::ENG_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               op_in         = cmd.op;
               res_value_in  = '0;
               res_status_in = bmhq_pkg::STATUS_OK;
               state_in      = bmhq_pkg::ENG_FINISH;
               case (cmd.op)
                  bmhq_pkg::OP_INSERT: begin
                     if (count_ff == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
                        res_status_in = bmhq_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        move_in  = cmd.value;
                        hole_in  = bmhq_pkg::ADDR_W'(count_ff);
                        if (count_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_addr = '0;
                           wr_data = cmd.value;
                        end else begin
                           rd_a_addr = bmhq_pkg::ADDR_W'(count_dec >> 1);
                           state_in  = bmhq_pkg::ENG_UP;
                        end
                     end
                  end
                  bmhq_pkg::OP_POLL, bmhq_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = bmhq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_a_addr = '0;
                        rd_b_addr = bmhq_pkg::ADDR_W'(count_dec);
                        state_in  = bmhq_pkg::ENG_ROOT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         bmhq_pkg::ENG_ROOT: begin
            res_value_in = rd_a_data_ff;
            state_in     = bmhq_pkg::ENG_FINISH;
            if (op_ff == bmhq_pkg::OP_POLL) begin
               // move the last entry into the root hole and, if more than one entry remains, start the walk down
               count_in = count_dec;
               move_in  = rd_b_data_ff;
               hole_in  = '0;
               if (count_dec == bmhq_pkg::CNT_W'(1)) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = rd_b_data_ff;
               end else if (count_dec != '0) begin
                  rd_a_addr = bmhq_pkg::ADDR_W'(1);
                  rd_b_addr = bmhq_pkg::ADDR_W'(2);
                  rt_ok_in  = (count_dec_ext > bmhq_pkg::IDX_W'(2));
                  state_in  = bmhq_pkg::ENG_DOWN;
               end
            end
         end

         bmhq_pkg::ENG_UP: begin
            if (rd_a_data_ff < move_ff) begin
               // pull the parent down into the hole and climb
               wr_en   = 1'b1;
               wr_addr = hole_ff;
               wr_data = rd_a_data_ff;
               hole_in = up_parent;
               if (up_parent == '0) begin
                  state_in = bmhq_pkg::ENG_PLACE;
               end else begin
                  rd_a_addr = (up_parent - 1'b1) >> 1;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = bmhq_pkg::ENG_FINISH;
            end
         end

         bmhq_pkg::ENG_DOWN: begin
            if (move_ff < pick_val) begin
               // lift the larger child into the hole and descend
               wr_en   = 1'b1;
               wr_addr = hole_ff;
               wr_data = pick_val;
               hole_in = pick_idx;
               if (next_left >= count_ext) begin
                  state_in = bmhq_pkg::ENG_PLACE;
               end else begin
                  rd_a_addr = bmhq_pkg::ADDR_W'(next_left);
                  rd_b_addr = bmhq_pkg::ADDR_W'(next_right);
                  rt_ok_in  = (next_right < count_ext);
               end
            end else begin
               wr_en    = 1'b1;
               state_in = bmhq_pkg::ENG_FINISH;
            end
         end

         bmhq_pkg::ENG_PLACE: begin
            wr_en    = 1'b1;
            state_in = bmhq_pkg::ENG_FINISH;
         end

         bmhq_pkg::ENG_FINISH: begin
            if (out_load) begin
               state_in = bmhq_pkg::ENG_IDLE;
            end
         end

         default: begin
            state_in = bmhq_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmhq_pkg::ENG_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hole_ff       <= hole_in;
      move_ff       <= move_in;
      op_ff         <= op_in;
      rt_ok_ff      <= rt_ok_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= heap_mem[rd_a_addr];
      rd_b_data_ff <= heap_mem[rd_b_addr];
   end

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entries_after = rsp_count_ff;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the binary max-heap priority queue.
`timescale 1ns / 100ps

module testbench;

   localparam logic [bmhq_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic signed [bmhq_pkg::VALUE_W-1:0] value;
      bmhq_pkg::status_type                status;
      logic [bmhq_pkg::CNT_W-1:0]          entries;
   } heap_result_type;

   // Mirror of the heap contents and the results that the block owes.
   class heap_tracker_type;
      logic signed [bmhq_pkg::VALUE_W-1:0] slot [bmhq_pkg::CAPACITY];
      int                                  held;
      heap_result_type                     owed_results[$];
      int                                  mismatches;

      function void swap_slots(int a, int b);
         logic signed [bmhq_pkg::VALUE_W-1:0] t;
         t = slot[a];
         slot[a] = slot[b];
         slot[b] = t;
      endfunction

      function void apply_operation(logic [bmhq_pkg::MODE_W-1:0] mode,
                                    logic signed [bmhq_pkg::VALUE_W-1:0] value);
         heap_result_type r;
         int pos, parent, left, right, pick;
         r.value = '0;
         r.status = bmhq_pkg::STATUS_OK;
         if (mode == bmhq_pkg::MODE_INSERT) begin
            if (held >= bmhq_pkg::CAPACITY) begin
               r.status = bmhq_pkg::STATUS_FULL;
            end else begin
               slot[held] = value;
               pos = held;
               held++;
               // climb while strictly greater than the parent
               while (pos != 0) begin
                  parent = (pos - 1) / 2;
                  if (!(slot[parent] < slot[pos])) break;
                  swap_slots(pos, parent);
                  pos = parent;
               end
            end
         end else if (mode == bmhq_pkg::MODE_POLL || mode == bmhq_pkg::MODE_PEEK) begin
            if (held == 0) begin
               r.status = bmhq_pkg::STATUS_EMPTY;
            end else begin
               r.value = slot[0];
               if (mode == bmhq_pkg::MODE_POLL) begin
                  held--;
                  slot[0] = slot[held];
                  pos = 0;
                  // descend toward the larger child, left on ties
                  forever begin
                     left = 2 * pos + 1;
                     right = left + 1;
                     if (left >= held) break;
                     pick = left;
                     if (right < held && slot[right] > slot[left]) pick = right;
                     if (!(slot[pos] < slot[pick])) break;
                     swap_slots(pos, pick);
                     pos = pick;
                  end
               end
            end
         end
         r.entries = bmhq_pkg::CNT_W'(held);
         owed_results.push_back(r);
      endfunction

      function void compare_result(logic signed [bmhq_pkg::VALUE_W-1:0] value,
                                   logic [bmhq_pkg::STATUS_W-1:0] status,
                                   logic [bmhq_pkg::CNT_W-1:0] entries);
         heap_result_type e;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected transaction, actual value %0d status %0d entries %0d",
                     $time, value, status, entries);
            mismatches++;
            return;
         end
         e = owed_results.pop_front();
         if (value !== e.value) begin
            $display("%0t: out_value mismatch, expected %0d actual %0d",
                     $time, e.value, value);
            mismatches++;
         end
         if (status !== e.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, e.status, status);
            mismatches++;
         end
         if (entries !== e.entries) begin
            $display("%0t: entries_after mismatch, expected %0d actual %0d",
                     $time, e.entries, entries);
            mismatches++;
         end
      endfunction
   endclass

   bit                                   clock;
   logic                                 reset;
   logic                                 req_push;
   logic                                 req_full;
   logic [bmhq_pkg::MODE_W-1:0]          req_mode;
   logic signed [bmhq_pkg::VALUE_W-1:0]  req_new_value;
   logic                                 rsp_empty;
   logic                                 rsp_pop;
   logic signed [bmhq_pkg::VALUE_W-1:0]  rsp_out_value;
   logic [bmhq_pkg::STATUS_W-1:0]        rsp_status;
   logic [bmhq_pkg::CNT_W-1:0]           rsp_entries_after;

   heap_tracker_type tracker;
   int               cycle_count;
   int               burst_left;
   logic [15:0]      pop_pattern;
   int               pop_index;

   binary_max_heap_queue_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_new_value     (req_new_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_entries_after (rsp_entries_after)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: check every popped transaction, stall on a rotating bit pattern.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         tracker.compare_result(rsp_out_value, rsp_status, rsp_entries_after);
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_index <= 0;
         pop_pattern <= 16'hFFFF;
      end else begin
         rsp_pop <= pop_pattern[pop_index];
         if (pop_index == 15) begin
            pop_index <= 0;
            if ($urandom_range(0, 3) == 0)
               pop_pattern <= 16'hFFFF;
            else
               pop_pattern <= 16'($urandom) | 16'h0001;
         end else begin
            pop_index <= pop_index + 1;
         end
      end
   end

   // Insert a gap between bursts of random length.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 12);
      end
   endtask

   // Hold the transaction until accepted, then record it.
   task automatic send_op(logic [bmhq_pkg::MODE_W-1:0] mode,
                          logic signed [bmhq_pkg::VALUE_W-1:0] value);
      req_push <= 1'b1;
      req_mode <= mode;
      req_new_value <= value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tracker.apply_operation(mode, value);
      pace();
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (tracker.owed_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [bmhq_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: pick_value = 32'h7FFF_FFFF;
         1: pick_value = 32'h8000_0000;
         2, 3, 4: pick_value = $signed($urandom_range(0, 8)) - 4;
         default: pick_value = $urandom;
      endcase
   endfunction

   function automatic logic [bmhq_pkg::MODE_W-1:0] pick_mode(int insert_weight);
      int r;
      r = $urandom_range(0, 99);
      if (r < insert_weight) pick_mode = bmhq_pkg::MODE_INSERT;
      else if (r < insert_weight + (95 - insert_weight) * 2 / 3) pick_mode = bmhq_pkg::MODE_POLL;
      else if (r < 95) pick_mode = bmhq_pkg::MODE_PEEK;
      else pick_mode = MODE_UNUSED;
   endfunction

   task automatic random_mix(int items, int insert_weight);
      for (int i = 0; i < items; i++)
         send_op(pick_mode(insert_weight), pick_value());
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_mode = bmhq_pkg::MODE_INSERT;
      req_new_value = '0;
      burst_left = 0;
      tracker = new;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty heap, unused mode, extremes, ties
      send_op(bmhq_pkg::MODE_PEEK, 32'hFFFF_FFFF);
      send_op(bmhq_pkg::MODE_POLL, 32'h0);
      send_op(MODE_UNUSED, 32'h1234_5678);
      send_op(bmhq_pkg::MODE_INSERT, 32'h7FFF_FFFF);
      send_op(bmhq_pkg::MODE_INSERT, 32'h8000_0000);
      send_op(bmhq_pkg::MODE_INSERT, 32'h0);
      send_op(bmhq_pkg::MODE_INSERT, -1);
      send_op(bmhq_pkg::MODE_INSERT, 5);
      send_op(bmhq_pkg::MODE_INSERT, 5);
      send_op(bmhq_pkg::MODE_PEEK, 32'h0);
      send_op(MODE_UNUSED, 32'h0);
      repeat (7) send_op(bmhq_pkg::MODE_POLL, 32'h0);
      send_op(bmhq_pkg::MODE_INSERT, 3);
      send_op(bmhq_pkg::MODE_INSERT, 3);
      send_op(bmhq_pkg::MODE_INSERT, 7);
      send_op(bmhq_pkg::MODE_INSERT, 3);
      repeat (3) send_op(bmhq_pkg::MODE_POLL, 32'h0);
      send_op(bmhq_pkg::MODE_PEEK, 32'h0);
      wait_for_drain();

      random_mix(400, 50);
      wait_for_drain();

      random_mix(400, 60);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.owed_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
